// ----- design/szr_pkg.sv -----
`default_nettype none
package szr_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int POS_W        = 32;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_COUNTED  = 2'd2;
  localparam logic [1:0] MODE_ZERO_RUN = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_COLUMN   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_MIDRUN   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
    logic       is_zero;
  } szr_item_t;

endpackage
`default_nettype wire

// ----- design/szr_in_if.sv -----
`default_nettype none
interface szr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface
`default_nettype wire

// ----- design/szr_out_if.sv -----
`default_nettype none
interface szr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic [7:0] run_length;
  logic       end_of_line;
  logic       end_of_image;
  logic [1:0] error_code;

  modport source (output valid, output pixel_value, output run_length, output end_of_line,
                  output end_of_image, output error_code, input ready);
  modport sink   (input valid, input pixel_value, input run_length, input end_of_line,
                  input end_of_image, input error_code, output ready);
endinterface
`default_nettype wire

// ----- design/scanline_zero_rle_decoder.sv -----
// A byte accepted on in_ch passes the byte queue and then the output register before its run
// can be taken from out_ch.
// Throughput: one byte per cycle from the back-end decode step unless out_ch stalls.
// A two-entry byte queue parts intake from decode; the output register parts decode
// from the consumer, so each side stalls on its own.
// Reset (rst_n low, synchronous): queue empty, no run pending, counters and config cleared.
`default_nettype none
module scanline_zero_rle_decoder #(
  parameter int DIM_BITS = szr_pkg::DIM_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  szr_in_if.sink                               in_ch,
  szr_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [szr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [szr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  szr_pkg::szr_item_t item;
  logic               item_valid;
  logic               item_take;

  szr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  szr_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ----- design/szr_front.sv -----
`default_nettype none
module szr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  szr_in_if.sink                 in_ch,
  output szr_pkg::szr_item_t     item,
  output logic                   item_valid,
  input  wire logic              item_take
);

  localparam int PTR_W = (szr_pkg::QUEUE_DEPTH > 1) ? $clog2(szr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(szr_pkg::QUEUE_DEPTH + 1);

  szr_pkg::szr_item_t q_r [szr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign in_ch.ready = (cnt_r != CNT_W'(szr_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (cnt_r != '0);
  assign pop         = item_valid && item_take;
  assign item        = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(szr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(szr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // classify on entry: flag the zero marker
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].data_byte      <= in_ch.data_byte;
      q_r[wr_ptr_r].start_of_image <= in_ch.start_of_image;
      q_r[wr_ptr_r].is_zero        <= (in_ch.data_byte == 8'd0);
    end
  end

endmodule
`default_nettype wire

// ----- design/szr_back.sv -----
`default_nettype none
module szr_back #(
  parameter int DIM_BITS = szr_pkg::DIM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [szr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [szr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire szr_pkg::szr_item_t              item,
  input  wire logic                           item_valid,
  output logic                                item_take,
  szr_out_if.source                           out_ch
);

  localparam int COL_W = DIM_BITS + 1;
  localparam int TOT_W = 2 * DIM_BITS;
  localparam int POS_W = szr_pkg::POS_W;

  typedef enum logic [3:0] {
    PH_COUNT_LO   = 4'b0001,
    PH_COUNT_HI   = 4'b0010,
    PH_DATA       = 4'b0100,
    PH_ZERO_COUNT = 4'b1000
  } szr_phase_t;

  logic [1:0]          mode_r;
  logic [DIM_BITS-1:0] width_r, height_r;
  logic [TOT_W-1:0]    total_r;

  szr_phase_t          phase_r, phase_nxt, ph;
  logic [7:0]          low_r, low_nxt, low;
  logic [15:0]         bl_r, bl_nxt, bl, bl_dec;
  logic [COL_W-1:0]    col_r, col_nxt, col, col_inc, clip;
  logic [DIM_BITS-1:0] row_r, row_nxt, row, row_inc;
  logic [POS_W-1:0]    pos_r, pos_nxt, pos, room, total_w;
  logic                halted_r, halted_nxt, hlt;

  logic [COL_W:0]      zsum;
  logic [7:0]          zlen;
  logic [15:0]         cnt16;
  logic                row_last;

  logic                res_v, res_eol, res_eoi;
  logic [7:0]          res_pix, res_len;
  logic [1:0]          res_err;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          pix_r, len_r;
  logic                eol_r, eoi_r;
  logic [1:0]          err_r;
  logic                go;

  assign item_take = !out_valid_r || out_ch.ready;
  assign go        = item_valid && item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          szr_pkg::CFG_MODE:   mode_r   <= cfg_data[1:0];
          szr_pkg::CFG_WIDTH:  width_r  <= cfg_data[DIM_BITS-1:0];
          szr_pkg::CFG_HEIGHT: height_r <= cfg_data[DIM_BITS-1:0];
          default: ;
        endcase
      end
      total_r <= width_r * height_r;
    end
  end

  always_comb begin
    ph  = phase_r;
    low = low_r;
    bl  = bl_r;
    col = col_r;
    row = row_r;
    pos = pos_r;
    hlt = halted_r;
    if (item.start_of_image) begin
      ph  = PH_COUNT_LO;
      low = '0;
      bl  = '0;
      col = '0;
      row = '0;
      pos = '0;
      hlt = 1'b0;
    end

    phase_nxt  = ph;
    low_nxt    = low;
    bl_nxt     = bl;
    col_nxt    = col;
    row_nxt    = row;
    pos_nxt    = pos;
    halted_nxt = hlt;

    res_v   = 1'b0;
    res_pix = '0;
    res_len = '0;
    res_eol = 1'b0;
    res_eoi = 1'b0;
    res_err = szr_pkg::ERR_NONE;

    total_w  = POS_W'(total_r);
    room     = (pos < total_w) ? total_w - pos : '0;
    row_inc  = row + 1'b1;
    row_last = (row_inc == height_r);
    bl_dec   = (bl != '0) ? bl - 1'b1 : '0;
    col_inc  = col + 1'b1;
    zsum     = {1'b0, col} + (COL_W + 1)'(item.data_byte);
    clip     = (col >= COL_W'(width_r)) ? '0 : COL_W'(width_r) - col;
    zlen     = (zsum > (COL_W + 1)'(width_r)) ? clip[7:0] : item.data_byte;
    cnt16    = {item.data_byte, low};

    if (!hlt && (row < height_r)) begin
      if (mode_r < szr_pkg::MODE_COUNTED) begin
        if (width_r != '0) begin
          pos_nxt = pos + 1'b1;
          col_nxt = col_inc;
          res_v   = 1'b1;
          res_pix = item.data_byte;
          res_len = 8'd1;
          if (col_inc >= COL_W'(width_r)) begin
            res_eol   = 1'b1;
            res_eoi   = row_last;
            col_nxt   = '0;
            phase_nxt = PH_COUNT_LO;
            row_nxt   = row_inc;
          end
        end
      end else begin
        case (ph)
          PH_COUNT_LO: begin
            low_nxt   = item.data_byte;
            phase_nxt = PH_COUNT_HI;
          end
          PH_COUNT_HI: begin
            bl_nxt = (cnt16 < 16'd2) ? '0 : cnt16 - 16'd2;
            if (cnt16 <= 16'd2) begin
              col_nxt   = '0;
              phase_nxt = PH_COUNT_LO;
              row_nxt   = row_inc;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            if (col > COL_W'(width_r)) begin
              halted_nxt = 1'b1;
              res_v      = 1'b1;
              res_err    = szr_pkg::ERR_COLUMN;
            end else begin
              bl_nxt = bl_dec;
              if ((mode_r == szr_pkg::MODE_ZERO_RUN) && item.is_zero) begin
                if (bl_dec == '0) begin
                  halted_nxt = 1'b1;
                  res_v      = 1'b1;
                  res_err    = szr_pkg::ERR_MIDRUN;
                end else begin
                  phase_nxt = PH_ZERO_COUNT;
                end
              end else if (room == '0) begin
                halted_nxt = 1'b1;
                res_v      = 1'b1;
                res_err    = szr_pkg::ERR_OVERFLOW;
              end else begin
                pos_nxt = pos + 1'b1;
                col_nxt = col_inc;
                res_v   = 1'b1;
                res_pix = item.data_byte;
                res_len = 8'd1;
                if (bl_dec == '0) begin
                  res_eol   = 1'b1;
                  res_eoi   = row_last;
                  col_nxt   = '0;
                  phase_nxt = PH_COUNT_LO;
                  row_nxt   = row_inc;
                end
              end
            end
          end
          PH_ZERO_COUNT: begin
            bl_nxt = bl_dec;
            if (POS_W'(zlen) > room) begin
              pos_nxt    = pos + room;
              halted_nxt = 1'b1;
              res_v      = 1'b1;
              res_len    = room[7:0];
              res_err    = szr_pkg::ERR_OVERFLOW;
            end else begin
              pos_nxt = pos + POS_W'(zlen);
              col_nxt = col + COL_W'(zlen);
              res_v   = (zlen != '0);
              res_len = zlen;
              if (bl_dec == '0) begin
                res_eol   = 1'b1;
                res_eoi   = row_last;
                col_nxt   = '0;
                phase_nxt = PH_COUNT_LO;
                row_nxt   = row_inc;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (go) begin
      out_valid_nxt = res_v;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COUNT_LO;
      low_r       <= '0;
      bl_r        <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        phase_r  <= phase_nxt;
        low_r    <= low_nxt;
        bl_r     <= bl_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        pos_r    <= pos_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_v) begin
      pix_r <= res_pix;
      len_r <= res_len;
      eol_r <= res_eol;
      eoi_r <= res_eoi;
      err_r <= res_err;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_value  = pix_r;
  assign out_ch.run_length   = len_r;
  assign out_ch.end_of_line  = eol_r;
  assign out_ch.end_of_image = eoi_r;
  assign out_ch.error_code   = err_r;

endmodule
`default_nettype wire

// ----- design/szr_checker.sv -----
`default_nettype none
module szr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] pixel_value,
  input wire logic [7:0] run_length,
  input wire logic       end_of_line,
  input wire logic       end_of_image,
  input wire logic [1:0] error_code
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(run_length) && $stable(error_code))
    else $error("run dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("run shown right after reset");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code != szr_pkg::ERR_NONE) |->
      (pixel_value == 8'd0) && !end_of_line && !end_of_image &&
      ((run_length == 8'd0) || (error_code == szr_pkg::ERR_OVERFLOW)))
    else $error("error item carries pixel data");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code == szr_pkg::ERR_NONE) |-> (run_length != 8'd0))
    else $error("empty run without error");

  a_eoi_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_image |-> end_of_line)
    else $error("image end without line end");

endmodule

bind scanline_zero_rle_decoder szr_checker u_szr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_value  (out_ch.pixel_value),
  .run_length   (out_ch.run_length),
  .end_of_line  (out_ch.end_of_line),
  .end_of_image (out_ch.end_of_image),
  .error_code   (out_ch.error_code)
);
`default_nettype wire
